// ===== rtl/hav_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hav_pkg
// widths, angle constants and cordic tables shared by the haversine datapath
// ----------------------------------------------------------------------------
package hav_pkg;

  localparam int ANGLE_FRAC_BITS = 30;
  localparam int CORDIC_STAGES   = 32;
  localparam int QS              = 62 - ANGLE_FRAC_BITS;
  localparam int SQ_SHIFT        = QS - (QS % 2);
  localparam int SQ_STAGES       = 32;
  localparam int SQ_TOP          = 62;
  localparam int VEC_SHIFT       = 29;

  localparam int HW  = 34;
  localparam int HX  = HW + 2;
  localparam int CW  = ANGLE_FRAC_BITS + 4;
  localparam int VW  = 64;
  localparam int RTW = 32;
  localparam int RW  = 23;
  localparam int RMW = 33;
  localparam int DW  = 35;
  localparam int AW  = ANGLE_FRAC_BITS + 1;

  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
  localparam logic [63:0] RAD_U  = (PI_Q60 * 64'd4 + 64'd1800000000) / 64'd3600000000;
  localparam logic signed [HW-1:0] RAD_S = HW'(RAD_U);

  localparam logic signed [HX-1:0] HALF_FULL    = HX'(64'd7200000000);
  localparam logic signed [HX-1:0] HALF_HALF    = HX'(64'd3600000000);
  localparam logic signed [HX-1:0] HALF_QUARTER = HX'(64'd1800000000);

  localparam logic [AW-1:0]  ONE_Q       = AW'(1) << ANGLE_FRAC_BITS;
  localparam logic [DW-1:0]  MAX_DIST    = DW'(64'd21991148576);
  localparam logic [RMW-1:0] RADIUS_MM_RST = RMW'(64'd6371000000);
  localparam logic [RMW-1:0] MM_PER_M    = RMW'(1000);

  function automatic logic [63:0] umulsh(input logic [63:0] a, input logic [63:0] b,
                                         input int s);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    return 64'(p >> s);
  endfunction

  function automatic logic signed [CW-1:0] atan_q(input int i);
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] v;
    int          k;
    sum = '0;
    if (i == 0) begin
      sum = PI_Q60;
    end else begin
      for (k = 0; i * (2 * k + 1) <= 62; k++) begin
        term = (64'h4000000000000000 >> (i * (2 * k + 1))) / 64'(2 * k + 1);
        if (k % 2 == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
    end
    v = (sum + (64'd1 << (QS - 1))) >> QS;
    return v[CW-1:0];
  endfunction

  function automatic logic signed [CW-1:0] gain_q();
    logic [63:0] p;
    logic [63:0] y;
    logic [63:0] t;
    logic [63:0] u;
    logic [63:0] w;
    logic [63:0] three;
    int          i;
    int          k;
    p     = 64'd1 << 63;
    three = 64'd3 << 62;
    for (i = 1; i < CORDIC_STAGES; i++) begin
      if (2 * i < 64) begin
        p = p + (p >> (2 * i));
      end
    end
    y = 64'd2767011611056432742;
    for (k = 0; k < 10; k++) begin
      t = umulsh(y, y, 62);
      u = umulsh(p, t, 62);
      w = (u < three) ? three - u : 64'd0;
      y = umulsh(y, w, 63);
    end
    w = (y + (64'd1 << (QS - 1))) >> QS;
    return w[CW-1:0];
  endfunction

  localparam logic signed [CW-1:0] GAIN_Q = gain_q();

  function automatic logic [CW-1:0] mag(input logic signed [CW-1:0] v);
    return v[CW-1] ? -v : v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/hav_rot.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hav_rot
// angle reduction and pipelined cordic rotation giving sine and cosine
// ----------------------------------------------------------------------------
module hav_rot (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_v,
  input  logic signed [hav_pkg::HW-1:0] in_angle,
  output logic                          out_v,
  output logic signed [hav_pkg::CW-1:0] out_sin,
  output logic signed [hav_pkg::CW-1:0] out_cos
);
  import hav_pkg::*;

  localparam int N  = CORDIC_STAGES;
  localparam int PW = 32 + HW;
  localparam logic signed [PW-1:0] RND = PW'(1) <<< (QS - 1);

  logic signed [HX-1:0] h_wrap;
  logic signed [HX-1:0] h_fold;
  logic                 neg_nxt;
  logic signed [31:0]   hf_r;
  logic                 red_neg_r;
  logic                 red_v_r;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] prod_rnd;

  logic signed [CW-1:0] x_r [0:N];
  logic signed [CW-1:0] y_r [0:N];
  logic signed [CW-1:0] z_r [0:N];
  logic                 neg_r [0:N];
  logic                 v_r [0:N];

  logic signed [CW-1:0] sin_r;
  logic signed [CW-1:0] cos_r;
  logic                 out_v_r;

  // wrap to half a turn, fold to a quarter turn
  always_comb begin
    h_wrap = HX'(in_angle);
    if (h_wrap > HALF_HALF) begin
      h_wrap = h_wrap - HALF_FULL;
    end else if (h_wrap < -HALF_HALF) begin
      h_wrap = h_wrap + HALF_FULL;
    end
    h_fold  = h_wrap;
    neg_nxt = 1'b0;
    if (h_wrap > HALF_QUARTER) begin
      h_fold  = HALF_HALF - h_wrap;
      neg_nxt = 1'b1;
    end else if (h_wrap < -HALF_QUARTER) begin
      h_fold  = -HALF_HALF - h_wrap;
      neg_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_v_r <= 1'b0;
    end else if (en) begin
      red_v_r <= in_v;
    end
    if (en) begin
      hf_r      <= h_fold[31:0];
      red_neg_r <= neg_nxt;
    end
  end

  // to radians
  always_comb begin
    prod     = PW'(hf_r) * PW'(RAD_S);
    prod_rnd = prod + RND;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= red_v_r;
    end
    if (en) begin
      z_r[0]   <= prod_rnd[QS +: CW];
      x_r[0]   <= GAIN_Q;
      y_r[0]   <= '0;
      neg_r[0] <= red_neg_r;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam logic signed [CW-1:0] ATAN_I = atan_q(i);
    logic signed [CW-1:0] x_nxt;
    logic signed [CW-1:0] y_nxt;
    logic signed [CW-1:0] z_nxt;

    always_comb begin
      if (!z_r[i][CW-1]) begin
        x_nxt = x_r[i] - (y_r[i] >>> i);
        y_nxt = y_r[i] + (x_r[i] >>> i);
        z_nxt = z_r[i] - ATAN_I;
      end else begin
        x_nxt = x_r[i] + (y_r[i] >>> i);
        y_nxt = y_r[i] - (x_r[i] >>> i);
        z_nxt = z_r[i] + ATAN_I;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
      end
      if (en) begin
        x_r[i+1]   <= x_nxt;
        y_r[i+1]   <= y_nxt;
        z_r[i+1]   <= z_nxt;
        neg_r[i+1] <= neg_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= v_r[N];
    end
    if (en) begin
      sin_r <= y_r[N];
      cos_r <= neg_r[N] ? -x_r[N] : x_r[N];
    end
  end

  assign out_v   = out_v_r;
  assign out_sin = sin_r;
  assign out_cos = cos_r;

endmodule
`default_nettype wire

// ===== rtl/hav_sqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hav_sqrt
// pipelined integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module hav_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_v,
  input  logic [63:0]                in_n,
  output logic                       out_v,
  output logic [hav_pkg::RTW-1:0]    out_root
);
  import hav_pkg::*;

  localparam int N = SQ_STAGES;

  logic [63:0] n_r [0:N];
  logic [63:0] r_r [0:N];
  logic        v_r [0:N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_v;
    end
    if (en) begin
      n_r[0] <= in_n;
      r_r[0] <= '0;
    end
  end

  for (genvar j = 0; j < N; j++) begin : g_stage
    localparam logic [63:0] BIT = 64'd1 << (SQ_TOP - 2 * j);
    logic [63:0] trial;
    logic [63:0] n_nxt;
    logic [63:0] r_nxt;

    always_comb begin
      trial = r_r[j] + BIT;
      if (n_r[j] >= trial) begin
        n_nxt = n_r[j] - trial;
        r_nxt = (r_r[j] >> 1) + BIT;
      end else begin
        n_nxt = n_r[j];
        r_nxt = r_r[j] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j+1] <= 1'b0;
      end else if (en) begin
        v_r[j+1] <= v_r[j];
      end
      if (en) begin
        n_r[j+1] <= n_nxt;
        r_r[j+1] <= r_nxt;
      end
    end
  end

  assign out_v    = v_r[N];
  assign out_root = r_r[N][RTW-1:0];

endmodule
`default_nettype wire

// ===== rtl/hav_vec.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hav_vec
// pipelined cordic vectoring giving the angle of (x, y), clamped at zero
// ----------------------------------------------------------------------------
module hav_vec (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_v,
  input  logic [hav_pkg::RTW-1:0]   in_rx,
  input  logic [hav_pkg::RTW-1:0]   in_ry,
  output logic                      out_v,
  output logic [hav_pkg::CW-2:0]    out_theta
);
  import hav_pkg::*;

  localparam int N = CORDIC_STAGES;

  logic signed [VW-1:0] x_r [0:N];
  logic signed [VW-1:0] y_r [0:N];
  logic signed [CW-1:0] z_r [0:N];
  logic                 v_r [0:N];
  logic [CW-2:0]        theta_r;
  logic                 out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_v;
    end
    if (en) begin
      x_r[0] <= $signed(VW'(in_rx) << VEC_SHIFT);
      y_r[0] <= $signed(VW'(in_ry) << VEC_SHIFT);
      z_r[0] <= '0;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam logic signed [CW-1:0] ATAN_I = atan_q(i);
    logic signed [VW-1:0] x_nxt;
    logic signed [VW-1:0] y_nxt;
    logic signed [CW-1:0] z_nxt;

    always_comb begin
      if (!y_r[i][VW-1]) begin
        x_nxt = x_r[i] + (y_r[i] >>> i);
        y_nxt = y_r[i] - (x_r[i] >>> i);
        z_nxt = z_r[i] + ATAN_I;
      end else begin
        x_nxt = x_r[i] - (y_r[i] >>> i);
        y_nxt = y_r[i] + (x_r[i] >>> i);
        z_nxt = z_r[i] - ATAN_I;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
      end
      if (en) begin
        x_r[i+1] <= x_nxt;
        y_r[i+1] <= y_nxt;
        z_r[i+1] <= z_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= v_r[N];
    end
    if (en) begin
      theta_r <= z_r[N][CW-1] ? '0 : z_r[N][CW-2:0];
    end
  end

  assign out_v     = out_v_r;
  assign out_theta = theta_r;

endmodule
`default_nettype wire

// ===== rtl/haversine_distance.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// haversine_distance
// great-circle distance in millimetres between two points given in 1e-7 deg
// ----------------------------------------------------------------------------
// input channel: in_valid/in_ready carry one word of two points (lat, lon).
// output channel: out_valid/out_ready carry one distance word per input word.
// cfg_wr_en/cfg_wr_data write the sphere radius in metres with no wait;
// write it only while no word is in flight. throughput: one word per cycle
// while the output buffer is not full.
// the pipeline holds four cordic units of 32 stages (rotation), 32 square
// root stages and 32 vectoring stages, plus the multiply stages between them.
// all stages advance together. a two-word output buffer sits at the end; the
// pipeline stops only when it is full, so in_ready stays high while one
// finished word waits, and in_ready does not depend on out_ready.
// during a stall every stage holds its word; nothing is lost or repeated.
// reset (rst_n low, synchronous) empties the pipeline and the output buffer
// and sets the radius to 6371000 m.
// ----------------------------------------------------------------------------
module haversine_distance (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [30:0]           in_first_latitude,
  input  logic signed [31:0]           in_first_longitude,
  input  logic signed [30:0]           in_second_latitude,
  input  logic signed [31:0]           in_second_longitude,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [hav_pkg::DW-1:0]       out_distance_mm,
  input  logic                         cfg_wr_en,
  input  logic [hav_pkg::RW-1:0]       cfg_wr_data
);
  import hav_pkg::*;

  localparam int F   = ANGLE_FRAC_BITS;
  localparam int PRW = RMW + CW;

  logic en;
  logic push;
  logic pop;

  logic [RMW-1:0] rmm_r;

  logic                 s0_v_r;
  logic signed [HW-1:0] h_dlat_r;
  logic signed [HW-1:0] h_dlon_r;
  logic signed [HW-1:0] h_lat1_r;
  logic signed [HW-1:0] h_lat2_r;

  logic                 rot_v;
  logic signed [CW-1:0] sdl;
  logic signed [CW-1:0] sdn;
  logic signed [CW-1:0] c1;
  logic signed [CW-1:0] c2;

  logic          t1_v_r;
  logic [63:0]   pc_r;
  logic          pc_neg_r;
  logic [63:0]   psl_r;
  logic [63:0]   psn_r;

  logic                 t2_v_r;
  logic signed [CW-1:0] c12_r;
  logic [CW-1:0]        sdl2_t2_r;
  logic [CW-1:0]        sdn2_r;

  logic          t3_v_r;
  logic [63:0]   pt_r;
  logic          pt_neg_r;
  logic [CW-1:0] sdl2_t3_r;

  logic                 t4_v_r;
  logic signed [CW-1:0] t_r;
  logic [CW-1:0]        sdl2_t4_r;

  logic signed [CW+1:0] a_sum;
  logic [AW-1:0]        a_nxt;
  logic                 t5_v_r;
  logic [AW-1:0]        a_r;

  logic [63:0]    sq_a;
  logic [63:0]    sq_b;
  logic           sq_v;
  logic [RTW-1:0] ry;
  logic [RTW-1:0] rx;

  logic          vec_v;
  logic [CW-2:0] theta;

  logic           f1_v_r;
  logic [PRW-1:0] fp_r;
  logic [PRW-F-1:0] dq;
  logic           f2_v_r;
  logic [DW-1:0]  d_r;

  logic [1:0]    fill_cnt_r;
  logic [1:0]    fill_cnt_nxt;
  logic [DW-1:0] head_r;
  logic [DW-1:0] head_nxt;
  logic [DW-1:0] spare_r;
  logic [DW-1:0] spare_nxt;

  assign en       = (fill_cnt_r != 2'd2);
  assign in_ready = en;
  assign push     = en && f2_v_r;
  assign pop      = out_valid && out_ready;

  // radius register, kept in millimetres
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rmm_r <= RADIUS_MM_RST;
    end else if (cfg_wr_en) begin
      rmm_r <= RMW'(cfg_wr_data) * MM_PER_M;
    end
  end

  // angles in half units of 0.5e-7 deg
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r <= in_valid;
    end
    if (en) begin
      h_dlat_r <= HW'(in_second_latitude) - HW'(in_first_latitude);
      h_dlon_r <= HW'(in_second_longitude) - HW'(in_first_longitude);
      h_lat1_r <= HW'(in_first_latitude) <<< 1;
      h_lat2_r <= HW'(in_second_latitude) <<< 1;
    end
  end

  hav_rot u_rot_dlat (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (s0_v_r),
    .in_angle (h_dlat_r),
    .out_v    (rot_v),
    .out_sin  (sdl),
    .out_cos  ()
  );

  hav_rot u_rot_dlon (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (s0_v_r),
    .in_angle (h_dlon_r),
    .out_v    (),
    .out_sin  (sdn),
    .out_cos  ()
  );

  hav_rot u_rot_lat1 (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (s0_v_r),
    .in_angle (h_lat1_r),
    .out_v    (),
    .out_sin  (),
    .out_cos  (c1)
  );

  hav_rot u_rot_lat2 (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (s0_v_r),
    .in_angle (h_lat2_r),
    .out_v    (),
    .out_sin  (),
    .out_cos  (c2)
  );

  // products of the haversine term, truncated toward zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_v_r <= 1'b0;
      t2_v_r <= 1'b0;
      t3_v_r <= 1'b0;
      t4_v_r <= 1'b0;
      t5_v_r <= 1'b0;
    end else if (en) begin
      t1_v_r <= rot_v;
      t2_v_r <= t1_v_r;
      t3_v_r <= t2_v_r;
      t4_v_r <= t3_v_r;
      t5_v_r <= t4_v_r;
    end
    if (en) begin
      pc_r      <= 64'(mag(c1)) * 64'(mag(c2));
      pc_neg_r  <= c1[CW-1] ^ c2[CW-1];
      psl_r     <= 64'(mag(sdl)) * 64'(mag(sdl));
      psn_r     <= 64'(mag(sdn)) * 64'(mag(sdn));

      c12_r     <= pc_neg_r ? -$signed(pc_r[F +: CW]) : $signed(pc_r[F +: CW]);
      sdl2_t2_r <= psl_r[F +: CW];
      sdn2_r    <= psn_r[F +: CW];

      pt_r      <= 64'(mag(c12_r)) * 64'(sdn2_r);
      pt_neg_r  <= c12_r[CW-1];
      sdl2_t3_r <= sdl2_t2_r;

      t_r       <= pt_neg_r ? -$signed(pt_r[F +: CW]) : $signed(pt_r[F +: CW]);
      sdl2_t4_r <= sdl2_t3_r;

      a_r       <= a_nxt;
    end
  end

  // clamp a to [0, 1]
  always_comb begin
    a_sum = $signed({2'b00, sdl2_t4_r}) + (CW+2)'(t_r);
    if (a_sum[CW+1]) begin
      a_nxt = '0;
    end else if (a_sum > (CW+2)'(ONE_Q)) begin
      a_nxt = ONE_Q;
    end else begin
      a_nxt = a_sum[AW-1:0];
    end
  end

  assign sq_a = 64'(a_r) << SQ_SHIFT;
  assign sq_b = 64'(ONE_Q - a_r) << SQ_SHIFT;

  hav_sqrt u_sqrt_a (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (t5_v_r),
    .in_n     (sq_a),
    .out_v    (sq_v),
    .out_root (ry)
  );

  hav_sqrt u_sqrt_b (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (t5_v_r),
    .in_n     (sq_b),
    .out_v    (),
    .out_root (rx)
  );

  hav_vec u_vec (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_v      (sq_v),
    .in_rx     (rx),
    .in_ry     (ry),
    .out_v     (vec_v),
    .out_theta (theta)
  );

  // scale by radius and saturate
  assign dq = fp_r[PRW-1:F];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
    end else if (en) begin
      f1_v_r <= vec_v;
      f2_v_r <= f1_v_r;
    end
    if (en) begin
      fp_r <= PRW'(rmm_r) * PRW'({theta, 1'b0});
      d_r  <= (dq > (PRW-F)'(MAX_DIST)) ? MAX_DIST : dq[DW-1:0];
    end
  end

  // two-word output buffer
  always_comb begin
    fill_cnt_nxt = fill_cnt_r;
    head_nxt     = head_r;
    spare_nxt    = spare_r;
    case (fill_cnt_r)
      2'd0: begin
        if (push) begin
          head_nxt     = d_r;
          fill_cnt_nxt = 2'd1;
        end
      end
      2'd1: begin
        if (push && pop) begin
          head_nxt = d_r;
        end else if (push) begin
          spare_nxt    = d_r;
          fill_cnt_nxt = 2'd2;
        end else if (pop) begin
          fill_cnt_nxt = 2'd0;
        end
      end
      2'd2: begin
        if (pop) begin
          head_nxt     = spare_r;
          fill_cnt_nxt = 2'd1;
        end
      end
      default: begin
        fill_cnt_nxt = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_cnt_r <= 2'd0;
    end else begin
      fill_cnt_r <= fill_cnt_nxt;
    end
    head_r  <= head_nxt;
    spare_r <= spare_nxt;
  end

  assign out_valid       = (fill_cnt_r != 2'd0);
  assign out_distance_mm = head_r;

`ifndef ASSERT_OFF
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_cnt_r != 2'd3)
    else $error("output buffer count out of range");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_cnt_r == 2'd2) |-> !push)
    else $error("word pushed into full output buffer");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!en && f2_v_r) |=> f2_v_r)
    else $error("last stage word lost during stall");

  a_full_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_cnt_r == 2'd2 && pop) |=> (fill_cnt_r == 2'd1 && out_valid))
    else $error("output buffer lost spare word");
`endif

endmodule
`default_nettype wire

// ===== test/tb_haversine_distance.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_haversine_distance
// checks the great-circle distance pipeline against a fixed-point predictor
// ----------------------------------------------------------------------------
// every accepted point pair is predicted with the same fixed-point haversine
// arithmetic (cordic sine/cosine, clamped a, integer square roots, cordic
// atan2) and the distances are compared in order. directed corner points,
// several sphere radii including the extremes, random pairs with random
// gaps on both channels, and a long output stall that backs up the input.
// ----------------------------------------------------------------------------
module tb_haversine_distance;
  import hav_pkg::*;

  localparam int FRAC = 30;
  localparam int STAGES = 32;
  localparam longint unsigned PI_Q60_U = 64'h3243F6A8885A308D;
  localparam longint FULL_TURN = 64'sd7200000000;
  localparam longint HALF_TURN = 64'sd3600000000;
  localparam longint QUARTER_TURN = 64'sd1800000000;
  localparam longint unsigned DIST_CAP = 64'd21991148576;
  localparam int LATENCY_WAIT = 200;
  localparam int CYCLE_LIMIT = 600000;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic signed [30:0] in_first_latitude = '0;
  logic signed [31:0] in_first_longitude = '0;
  logic signed [30:0] in_second_latitude = '0;
  logic signed [31:0] in_second_longitude = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [DW-1:0] out_distance_mm;
  logic cfg_wr_en = 0;
  logic [RW-1:0] cfg_wr_data = '0;

  haversine_distance uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_first_latitude(in_first_latitude), .in_first_longitude(in_first_longitude),
    .in_second_latitude(in_second_latitude), .in_second_longitude(in_second_longitude),
    .out_valid(out_valid), .out_ready(out_ready), .out_distance_mm(out_distance_mm),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  longint atan_tab [STAGES];
  longint cordic_gain;
  longint rad_per_half;
  longint unsigned radius_m = 6371000;
  logic [DW-1:0] expected_distances [$];
  int errors = 0;
  int cycles = 0;
  int stall_pct = 0;
  int gap_pct = 0;
  int hold_request = 0;
  int hold_left = 0;

  function automatic longint unsigned mul_shift(longint unsigned a, longint unsigned b, int s);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    return 64'(p >> s);
  endfunction

  function automatic longint unsigned round_to_frac(longint unsigned v);
    return (v + (64'd1 << (61 - FRAC))) >> (62 - FRAC);
  endfunction

  function automatic void build_tables();
    longint unsigned term, p, y, t, u, w;
    longint sum;
    for (int i = 0; i < STAGES; i++) begin
      sum = 0;
      if (i == 0) begin
        sum = PI_Q60_U;
      end else begin
        for (int k = 0; i * (2 * k + 1) <= 62; k++) begin
          term = (64'h4000000000000000 >> (i * (2 * k + 1))) / longint'(2 * k + 1);
          sum = (k % 2 == 1) ? sum - longint'(term) : sum + longint'(term);
        end
      end
      atan_tab[i] = round_to_frac(sum);
    end
    p = 64'd1 << 63;
    for (int i = 1; i < STAGES; i++) p = p + (p >> (2 * i));
    y = 64'd2767011611056432742;
    for (int k = 0; k < 10; k++) begin
      t = mul_shift(y, y, 62);
      u = mul_shift(p, t, 62);
      w = (u < (64'd3 << 62)) ? (64'd3 << 62) - u : 64'd0;
      y = mul_shift(y, w, 63);
    end
    cordic_gain = round_to_frac(y);
    rad_per_half = (PI_Q60_U * 64'd4 + 64'd1800000000) / 64'd3600000000;
  endfunction

  function automatic longint mul_frac(longint a, longint b);
    longint unsigned ua, ub;
    longint r;
    ua = a < 0 ? -a : a;
    ub = b < 0 ? -b : b;
    r = mul_shift(ua, ub, FRAC);
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  // h in units of 0.5e-7 degree
  function automatic void sine_cosine(input longint h, output longint s, output longint c);
    longint x, y, z, dx, dy;
    bit flip;
    flip = 0;
    x = cordic_gain;
    y = 0;
    h = h % FULL_TURN;
    if (h > HALF_TURN) h -= FULL_TURN;
    if (h < -HALF_TURN) h += FULL_TURN;
    if (h > QUARTER_TURN) begin
      h = HALF_TURN - h;
      flip = 1;
    end else if (h < -QUARTER_TURN) begin
      h = -HALF_TURN - h;
      flip = 1;
    end
    z = (h * rad_per_half + (64'sd1 <<< (61 - FRAC))) >>> (62 - FRAC);
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    s = y;
    c = flip ? -x : x;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [DW-1:0] predict_distance(longint lat1, longint lon1,
                                                      longint lat2, longint lon2);
    longint sdl, cdl, sdn, cdn, s1, c1, s2, c2, a, x, y, z, dx, dy;
    longint one;
    longint unsigned d;
    int e;
    one = 64'sd1 <<< FRAC;
    e = (62 - FRAC) & ~1;
    sine_cosine(lat2 - lat1, sdl, cdl);
    sine_cosine(lon2 - lon1, sdn, cdn);
    sine_cosine(2 * lat1, s1, c1);
    sine_cosine(2 * lat2, s2, c2);
    a = mul_frac(sdl, sdl) + mul_frac(mul_frac(c1, c2), mul_frac(sdn, sdn));
    if (a < 0) a = 0;
    if (a > one) a = one;
    y = int_sqrt(longint'(a) << e) << 29;
    x = int_sqrt(longint'(one - a) << e) << 29;
    z = 0;
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_tab[i];
      end else begin
        x -= dx; y += dy; z -= atan_tab[i];
      end
    end
    if (z < 0) z = 0;
    d = mul_shift(radius_m * 1000, z * 2, FRAC);
    if (d > DIST_CAP) d = DIST_CAP;
    return d[DW-1:0];
  endfunction

  // output side: random stalls plus an optional long hold
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct) ||
                   ($urandom_range(99) < 2 ? 1'b0 : 1'b0);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_distances.size() == 0) begin
        $display("%0t: unexpected distance word %0d", $time, out_distance_mm);
        errors++;
      end else begin
        if (out_distance_mm !== expected_distances[0]) begin
          $display("%0t: distance_mm expected %0d actual %0d", $time,
                   expected_distances[0], out_distance_mm);
          errors++;
        end
        void'(expected_distances.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if ($urandom_range(99) >= gap_pct) return 0;
    r = $urandom_range(99);
    if (r < 85) return $urandom_range(3, 1);
    return $urandom_range(40, 4);
  endfunction

  task automatic send_points(longint lat1, longint lon1, longint lat2, longint lon2, int gap);
    logic signed [30:0] a1, a2;
    logic signed [31:0] o1, o2;
    a1 = lat1[30:0];
    o1 = lon1[31:0];
    a2 = lat2[30:0];
    o2 = lon2[31:0];
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_first_latitude <= a1;
    in_first_longitude <= o1;
    in_second_latitude <= a2;
    in_second_longitude <= o2;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    expected_distances.push_back(predict_distance(a1, o1, a2, o2));
  endtask

  task automatic drain();
    in_valid <= 0;
    while (expected_distances.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_radius(longint unsigned r);
    drain();
    cfg_wr_en <= 1;
    cfg_wr_data <= r[RW-1:0];
    @(posedge clk);
    cfg_wr_en <= 0;
    radius_m = r & 64'h7FFFFF;
    @(posedge clk);
  endtask

  function automatic longint rand_lat();
    return longint'($urandom_range(1800000000)) - 900000000;
  endfunction

  function automatic longint rand_lon();
    return longint'($urandom_range(32'd3600000000, 0)) - 1800000000;
  endfunction

  task automatic test_corner_points();
    stall_pct = 0;
    gap_pct = 0;
    send_points(0, 0, 0, 0, 0);
    send_points(900000000, 0, -900000000, 0, 0);
    send_points(0, -1800000000, 0, 1800000000, 0);
    send_points(0, 0, 0, 1800000000, 0);
    send_points(0, 0, 0, -1800000000, 0);
    send_points(450000000, 900000000, -450000000, -900000000, 0);
    send_points(900000000, 1234567, 900000000, -7654321, 0);
    send_points(-900000000, 0, 900000000, 1800000000, 0);
    send_points(0, 1799999999, 0, -1799999999, 0);
    send_points(10, 10, 11, 11, 0);
    send_points(-(1 << 30), -(64'sd1 << 31), (1 << 30) - 1, (64'sd1 << 31) - 1, 0);
    send_points((1 << 30) - 1, (64'sd1 << 31) - 1, -(1 << 30), -(64'sd1 << 31), 0);
    send_points(-(1 << 30), 0, -(1 << 30), 0, 0);
    send_points(1000000000, 500000000, -1000000000, -2000000000, 0);
    send_points(300000000, -1700000000, 300000000, 1700000000, 0);
    send_points(-1, -1, 1, 1, 0);
    drain();
  endtask

  task automatic test_radius_extremes();
    longint unsigned radii [4] = '{6000000, 7000000, 64'h7FFFFF, 0};
    foreach (radii[i]) begin
      set_radius(radii[i]);
      send_points(900000000, 0, -900000000, 0, 0);
      send_points(0, 0, 0, 1800000000, 0);
      send_points(123456789, -456789012, -98765432, 1111111111, 0);
      send_points(0, 0, 10, 0, 0);
    end
    drain();
  endtask

  task automatic test_random_pairs(int count);
    longint la1, lo1, la2, lo2;
    int kind;
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) begin
        stall_pct = $urandom_range(3) * 20;
        gap_pct = $urandom_range(3) * 20;
      end
      kind = $urandom_range(99);
      la1 = rand_lat();
      lo1 = rand_lon();
      if (kind < 60) begin
        la2 = rand_lat();
        lo2 = rand_lon();
      end else if (kind < 80) begin
        la2 = la1 + longint'($urandom_range(20000)) - 10000;
        lo2 = lo1 + longint'($urandom_range(20000)) - 10000;
      end else if (kind < 90) begin
        la2 = -la1 + longint'($urandom_range(200)) - 100;
        lo2 = lo1 + 1800000000 + longint'($urandom_range(200)) - 100;
      end else begin
        la1 = longint'(signed'(31'($urandom())));
        lo1 = longint'(signed'($urandom()));
        la2 = longint'(signed'(31'($urandom())));
        lo2 = longint'(signed'($urandom()));
      end
      send_points(la1, lo1, la2, lo2, pick_gap());
    end
    drain();
  endtask

  task automatic test_output_backpressure();
    gap_pct = 0;
    stall_pct = 0;
    hold_request = 400;
    for (int n = 0; n < 250; n++) send_points(rand_lat(), rand_lon(), rand_lat(), rand_lon(), 0);
    drain();
  endtask

  initial begin
    build_tables();
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_corner_points();
    test_radius_extremes();
    set_radius(6371000);
    test_random_pairs(400);
    set_radius(6000000);
    test_random_pairs(300);
    set_radius(7000000);
    test_random_pairs(300);
    set_radius(64'h7FFFFF);
    test_random_pairs(200);
    set_radius(6000000 + $urandom_range(1000000));
    test_random_pairs(300);
    test_output_backpressure();
    stall_pct = 30;
    repeat (LATENCY_WAIT) @(posedge clk);
    if (errors == 0 && expected_distances.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
